// ===== hdl/tkd_pkg.sv =====
package tkd_pkg;

	localparam int KB_TOP    = 279;
	localparam int ROW_PITCH = 51;
	localparam int ROW_H     = 48;
	localparam int ROWS      = 4;
	localparam int COLS      = 10;
	localparam int LAYOUTS   = 4;

	localparam logic [15:0] WINDOW_RESET = 16'd400;

	typedef enum logic [2:0] {
		ACT_NONE       = 3'd0,
		ACT_INSERT     = 3'd1,
		ACT_INS_FULL   = 3'd2,
		ACT_DELETE     = 3'd3,
		ACT_DEL_EMPTY  = 3'd4,
		ACT_ACCEPT     = 3'd5,
		ACT_LAYOUT     = 3'd6
	} action_t;

	typedef enum logic [1:0] {
		SHIFT_IDLE   = 2'd0,
		SHIFT_SINGLE = 2'd1,
		SHIFT_HELD   = 2'd2
	} shift_t;

	typedef logic [1:0] layout_t;
	localparam layout_t LAYOUT_LOWER = 2'd0;
	localparam layout_t LAYOUT_UPPER = 2'd1;
	localparam layout_t LAYOUT_SYM1  = 2'd2;
	localparam layout_t LAYOUT_SYM2  = 2'd3;

	localparam logic REQ_START   = 1'b0;
	localparam logic REQ_RELEASE = 1'b1;

	typedef logic [8:0] key_t;
	localparam key_t K_NONE  = 9'h000;
	localparam key_t K_SHIFT = 9'h100;
	localparam key_t K_DEL   = 9'h101;
	localparam key_t K_OK    = 9'h102;
	localparam key_t K_SYM1  = 9'h103;
	localparam key_t K_SYM2  = 9'h104;
	localparam key_t K_ABC   = 9'h105;

	// row shape per layout: ten keys, nine keys (ten in the symbol layouts), shift row, bottom row
	localparam logic [1:0] ROW_SHAPE [LAYOUTS][ROWS] = '{
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd1, 2'd2, 2'd3},
		'{2'd0, 2'd0, 2'd2, 2'd3},
		'{2'd0, 2'd0, 2'd2, 2'd3}
	};

	// key span per shape: x_start <= x < x_end; empty slots have zero width
	localparam logic [9:0] KEY_XS [4][COLS] = '{
		'{10'd4, 10'd51, 10'd98, 10'd145, 10'd192, 10'd239, 10'd286, 10'd333, 10'd380,
			10'd427},
		'{10'd4, 10'd56, 10'd108, 10'd160, 10'd212, 10'd264, 10'd316, 10'd368, 10'd420,
			10'd0},
		'{10'd4, 10'd88, 10'd131, 10'd174, 10'd217, 10'd260, 10'd303, 10'd346, 10'd389,
			10'd0},
		'{10'd4, 10'd90, 10'd134, 10'd346, 10'd390, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0}
	};
	localparam logic [9:0] KEY_XE [4][COLS] = '{
		'{10'd48, 10'd95, 10'd142, 10'd189, 10'd236, 10'd283, 10'd330, 10'd377, 10'd424,
			10'd471},
		'{10'd53, 10'd105, 10'd157, 10'd209, 10'd261, 10'd313, 10'd365, 10'd417, 10'd469,
			10'd0},
		'{10'd85, 10'd128, 10'd171, 10'd214, 10'd257, 10'd300, 10'd343, 10'd386, 10'd470,
			10'd0},
		'{10'd87, 10'd131, 10'd343, 10'd387, 10'd473, 10'd0, 10'd0, 10'd0, 10'd0, 10'd0}
	};

	localparam key_t KEY_MAP [LAYOUTS][ROWS][COLS] = '{
		'{
			'{9'("q"), 9'("w"), 9'("e"), 9'("r"), 9'("t"), 9'("y"), 9'("u"), 9'("i"),
				9'("o"), 9'("p")},
			'{9'("a"), 9'("s"), 9'("d"), 9'("f"), 9'("g"), 9'("h"), 9'("j"), 9'("k"),
				9'("l"), K_NONE},
			'{K_SHIFT, 9'("z"), 9'("x"), 9'("c"), 9'("v"), 9'("b"), 9'("n"), 9'("m"),
				K_DEL, K_NONE},
			'{K_SYM1, 9'(","), 9'(" "), 9'("."), K_OK, K_NONE, K_NONE, K_NONE, K_NONE,
				K_NONE}
		},
		'{
			'{9'("Q"), 9'("W"), 9'("E"), 9'("R"), 9'("T"), 9'("Y"), 9'("U"), 9'("I"),
				9'("O"), 9'("P")},
			'{9'("A"), 9'("S"), 9'("D"), 9'("F"), 9'("G"), 9'("H"), 9'("J"), 9'("K"),
				9'("L"), K_NONE},
			'{K_SHIFT, 9'("Z"), 9'("X"), 9'("C"), 9'("V"), 9'("B"), 9'("N"), 9'("M"),
				K_DEL, K_NONE},
			'{K_SYM1, 9'(","), 9'(" "), 9'("."), K_OK, K_NONE, K_NONE, K_NONE, K_NONE,
				K_NONE}
		},
		'{
			'{9'("1"), 9'("2"), 9'("3"), 9'("4"), 9'("5"), 9'("6"), 9'("7"), 9'("8"),
				9'("9"), 9'("0")},
			'{9'("@"), 9'("#"), 9'("$"), 9'("_"), 9'("&"), 9'("-"), 9'("+"), 9'("("),
				9'(")"), 9'("/")},
			'{K_SYM2, 9'("*"), 9'h022, 9'h027, 9'(":"), 9'(";"), 9'("!"), 9'("?"),
				K_DEL, K_NONE},
			'{K_ABC, 9'(","), 9'(" "), 9'("."), K_OK, K_NONE, K_NONE, K_NONE, K_NONE,
				K_NONE}
		},
		'{
			'{9'("~"), 9'h060, 9'("|"), 9'("^"), 9'("%"), 9'h05C, 9'("["), 9'("]"),
				9'("{"), 9'("}")},
			'{9'("<"), 9'(">"), 9'("="), 9'("@"), 9'("#"), 9'("$"), 9'("&"), 9'("*"),
				9'("+"), 9'("-")},
			'{K_SYM1, 9'("!"), 9'("?"), 9'("/"), 9'("_"), 9'("("), 9'(")"), 9'(":"),
				K_DEL, K_NONE},
			'{K_ABC, 9'(","), 9'(" "), 9'("."), K_OK, K_NONE, K_NONE, K_NONE, K_NONE,
				K_NONE}
		}
	};

endpackage

// ===== hdl/tkd_if.sv =====
interface tkd_req_if;
	logic        valid;
	logic        ready;
	logic        req_type;
	logic [6:0]  start_length;
	logic [9:0]  touch_x;
	logic [9:0]  touch_y;
	logic [31:0] time_ms;

	modport source (output valid, req_type, start_length, touch_x, touch_y, time_ms,
		input ready);
	modport sink (input valid, req_type, start_length, touch_x, touch_y, time_ms,
		output ready);
endinterface

interface tkd_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] action;
	logic [7:0] char_code;
	logic [6:0] text_length;
	logic [1:0] layout;
	logic [1:0] shift_mode;

	modport source (output valid, action, char_code, text_length, layout, shift_mode,
		input ready);
	modport sink (input valid, action, char_code, text_length, layout, shift_mode,
		output ready);
endinterface

// ===== hdl/touch_keyboard_key_decoder.sv =====
// channel  dir  handshake      word
// req      in   valid/ready    req_type, start_length, touch_x, touch_y, time_ms
// rsp      out  valid/ready    action, char_code, text_length, layout, shift_mode
// cfg      in   cfg_we         cfg_wdata = double-tap window (ms)
//
// One word per cycle sustained while rsp is not stalled. An accepted word goes to the
// input register, then key lookup and state update into the result register (rsp.valid).
// req.ready drops only while both registers hold words and rsp is stalled.
// arst_n clears valids, layout lower, shift off, length 0; window resets to 400.
module touch_keyboard_key_decoder #(
	parameter int MAX_TEXT = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	tkd_req_if.sink       req,
	tkd_rsp_if.source     rsp,
	input  logic          cfg_we,
	input  logic [15:0]   cfg_wdata
);
	import tkd_pkg::*;

	localparam int LEN_CAP_I = (MAX_TEXT > 127) ? 127 : MAX_TEXT;
	localparam logic [6:0] LEN_CAP = 7'(LEN_CAP_I);

	logic [15:0] window_q;

	logic        valid_s1;
	logic        req_type_s1;
	logic [6:0]  start_length_s1;
	logic [9:0]  touch_x_s1;
	logic [9:0]  touch_y_s1;
	logic [31:0] time_ms_s1;

	logic        valid_s2;
	action_t     action_s2;
	logic [7:0]  char_code_s2;

	layout_t     layout_q;
	shift_t      shift_q;
	logic [31:0] last_shift_q;
	logic [6:0]  length_q;
	logic        done_q;

	layout_t     layout_d;
	shift_t      shift_d;
	logic [31:0] last_shift_d;
	logic [6:0]  length_d;
	logic        done_d;
	action_t     action_d;
	logic [7:0]  char_d;

	logic        advance;
	logic        row_hit;
	logic [1:0]  row_idx;
	logic        col_hit;
	logic [3:0]  col_idx;
	logic [1:0]  shape;
	key_t        key;
	logic        dbl_tap;
	logic [31:0] tap_gap;

	assign advance   = valid_s1 && (!valid_s2 || rsp.ready);
	assign req.ready = !valid_s1 || !valid_s2 || rsp.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_q <= WINDOW_RESET;
		end else if (cfg_we) begin
			window_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.ready && req.valid) begin
			req_type_s1     <= req.req_type;
			start_length_s1 <= req.start_length;
			touch_x_s1      <= req.touch_x;
			touch_y_s1      <= req.touch_y;
			time_ms_s1      <= req.time_ms;
		end
	end

	// row and column by parallel compares against fixed key spans
	always_comb begin
		row_hit = 1'b0;
		row_idx = '0;
		for (int r = 0; r < ROWS; r++) begin
			if (touch_y_s1 >= 10'(KB_TOP + ROW_PITCH * r) &&
				touch_y_s1 < 10'(KB_TOP + ROW_PITCH * r + ROW_H)) begin
				row_hit = 1'b1;
				row_idx = 2'(r);
			end
		end
		shape   = ROW_SHAPE[layout_q][row_idx];
		col_hit = 1'b0;
		col_idx = '0;
		for (int c = 0; c < COLS; c++) begin
			if (touch_x_s1 >= KEY_XS[shape][c] && touch_x_s1 < KEY_XE[shape][c]) begin
				col_hit = 1'b1;
				col_idx = 4'(c);
			end
		end
		key = (row_hit && col_hit) ? KEY_MAP[layout_q][row_idx][col_idx] : K_NONE;
	end

	assign tap_gap = time_ms_s1 - last_shift_q;
	assign dbl_tap = tap_gap < {16'd0, window_q};

	always_comb begin
		layout_d     = layout_q;
		shift_d      = shift_q;
		last_shift_d = last_shift_q;
		length_d     = length_q;
		done_d       = done_q;
		action_d     = ACT_NONE;
		char_d       = '0;
		if (req_type_s1 == REQ_START) begin
			length_d     = (start_length_s1 > LEN_CAP) ? LEN_CAP : start_length_s1;
			layout_d     = LAYOUT_LOWER;
			shift_d      = SHIFT_IDLE;
			last_shift_d = '0;
			done_d       = 1'b0;
		end else if (!done_q) begin
			priority if (key == K_SHIFT) begin
				unique case (shift_q)
					SHIFT_IDLE: begin
						shift_d  = dbl_tap ? SHIFT_HELD : SHIFT_SINGLE;
						layout_d = LAYOUT_UPPER;
					end
					SHIFT_SINGLE: begin
						if (dbl_tap) begin
							shift_d = SHIFT_HELD;
						end else begin
							shift_d  = SHIFT_IDLE;
							layout_d = LAYOUT_LOWER;
						end
					end
					default: begin
						shift_d  = SHIFT_IDLE;
						layout_d = LAYOUT_LOWER;
					end
				endcase
				last_shift_d = time_ms_s1;
				action_d     = ACT_LAYOUT;
			end else if (key == K_SYM1) begin
				layout_d = LAYOUT_SYM1;
				action_d = ACT_LAYOUT;
			end else if (key == K_SYM2) begin
				layout_d = LAYOUT_SYM2;
				action_d = ACT_LAYOUT;
			end else if (key == K_ABC) begin
				layout_d = (shift_q != SHIFT_IDLE) ? LAYOUT_UPPER : LAYOUT_LOWER;
				action_d = ACT_LAYOUT;
			end else if (key == K_OK) begin
				done_d   = 1'b1;
				action_d = ACT_ACCEPT;
			end else if (key == K_DEL) begin
				if (length_q != '0) begin
					length_d = length_q - 7'd1;
					action_d = ACT_DELETE;
				end else begin
					action_d = ACT_DEL_EMPTY;
				end
			end else if (key != K_NONE) begin
				if (length_q < LEN_CAP) begin
					length_d = length_q + 7'd1;
					action_d = ACT_INSERT;
					char_d   = key[7:0];
				end else begin
					action_d = ACT_INS_FULL;
				end
				// one-shot shift drops after any character, refused or not
				if (shift_q == SHIFT_SINGLE) begin
					shift_d  = SHIFT_IDLE;
					layout_d = LAYOUT_LOWER;
				end
			end else begin
				action_d = ACT_NONE;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			layout_q     <= LAYOUT_LOWER;
			shift_q      <= SHIFT_IDLE;
			last_shift_q <= '0;
			length_q     <= '0;
			done_q       <= 1'b0;
		end else if (advance) begin
			layout_q     <= layout_d;
			shift_q      <= shift_d;
			last_shift_q <= last_shift_d;
			length_q     <= length_d;
			done_q       <= done_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (rsp.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			action_s2    <= action_d;
			char_code_s2 <= char_d;
		end
	end

	// state registers update with the result, so they read as this word's outcome
	assign rsp.valid       = valid_s2;
	assign rsp.action      = action_s2;
	assign rsp.char_code   = char_code_s2;
	assign rsp.text_length = length_q;
	assign rsp.layout      = layout_q;
	assign rsp.shift_mode  = shift_q;

endmodule
